>>> sv/serial_eeprom_three_wire_interface_core_macros.svh
// ---------------------------------------------------------------------------
// serial eeprom three-wire interface - assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ---------------------------------------------------------------------------
`ifndef SERIAL_EEPROM_THREE_WIRE_INTERFACE_CORE_MACROS_SVH
`define SERIAL_EEPROM_THREE_WIRE_INTERFACE_CORE_MACROS_SVH

// same-cycle implication
`define SETWI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("setwi assertion failed");

// next-cycle implication
`define SETWI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("setwi assertion failed");

`endif

>>> sv/setwi_pkg.sv
// ---------------------------------------------------------------------------
// setwi_pkg
// Types and constants shared by the serial eeprom interface modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package setwi_pkg;

  // word store geometry (power of two, 64 to 256 words)
  localparam int WORDS  = 256;
  localparam int ADDR_W = $clog2(WORDS);
  localparam int WORD_W = 16;
  localparam int CNT_W  = 5;

  localparam logic [WORD_W-1:0] ERASED_WORD = '1;

  // bit counts that close each field
  localparam logic [CNT_W-1:0] CNT_OPCODE = 5'd2;
  localparam logic [CNT_W-1:0] CNT_ADDR   = 5'd8;
  localparam logic [CNT_W-1:0] CNT_WORD   = 5'd16;
  localparam logic [CNT_W-1:0] CNT_READ   = 5'd1;

  // command decode phase
  typedef enum logic [2:0] {
    PH_NONE  = 3'd0,
    PH_OP    = 3'd1,
    PH_ADDR  = 3'd2,
    PH_DATA  = 3'd3,
    PH_RDOUT = 3'd4,
    PH_WAIT  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    OP_EXT   = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_ERASE = 2'd3
  } op_e;

  // extended commands, taken from address bits 7..6
  typedef enum logic [1:0] {
    EXT_EWDS = 2'd0,
    EXT_WRAL = 2'd1,
    EXT_ERAL = 2'd2,
    EXT_EWEN = 2'd3
  } ext_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LOAD = 1'b1
  } state_e;

  // request from the controller to the word store
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic              fill_en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
    logic [WORD_W-1:0] fill_data;
  } store_req_t;

endpackage

>>> sv/serial_eeprom_three_wire_interface_core.sv
// ---------------------------------------------------------------------------
// serial_eeprom_three_wire_interface_core
// Three-wire serial EEPROM of 256 sixteen-bit words driven by control writes.
// ---------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid_i / in_stall_o) carries command_i and
//  control_byte_i. command_i = 0 applies control_byte_i (bit 7 select,
//  bit 6 serial clock, bit 1 data in); command_i = 1 only samples data out.
//  Every transfer yields exactly one result transfer on the output channel
//  (out_valid_o / out_stall_i) with data_out_o, the data-out / ready bit.
//  The result is registered and appears in the cycle after the input transfer.
//  The input takes one item per cycle while the receiver does not stall,
//  except that after the item that completes a read command it stalls in
//  the load state while the addressed word comes out of the RAM's registered read port.
//  Write-all and erase-all act through per-word valid bits and a fill
//  value in front of the RAM.
//  Reset: the store reads as all ones, writing is disabled, the data-out
//  bit held by the controller is 1; no clearing pass is needed.
//  While the receiver stalls with a result held, the input is stalled too.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_eeprom_three_wire_interface_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [7:0] control_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       data_out_o
);
  import setwi_pkg::*;

  store_req_t        store_req;
  logic [WORD_W-1:0] store_rdata;
  logic              res_valid;
  logic              res_bit;
  logic              res_busy;
  logic              out_valid_q;
  logic              data_out_q;

  setwi_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .control_byte_i (control_byte_i),
    .res_busy_i     (res_busy),
    .res_valid_o    (res_valid),
    .res_bit_o      (res_bit),
    .store_req_o    (store_req),
    .store_rdata_i  (store_rdata)
  );

  setwi_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (store_req),
    .rd_data_o (store_rdata)
  );

  // output register holds a result until its transfer
  assign res_busy = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!res_busy) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      data_out_q <= res_bit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = data_out_q;

endmodule

>>> sv/setwi_ram.sv
// ---------------------------------------------------------------------------
// setwi_ram
// Single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module setwi_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

>>> sv/setwi_store.sv
// ---------------------------------------------------------------------------
// setwi_store
// Word store: RAM plus per-word valid bits and a fill value, so that reset
// and the fill-all commands take effect at once.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module setwi_store (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  setwi_pkg::store_req_t             req_i,
  output logic [setwi_pkg::WORD_W-1:0]      rd_data_o
);
  import setwi_pkg::*;

  logic [WORDS-1:0]  valid_q, valid_d;
  logic [WORD_W-1:0] fill_q, fill_d;
  logic              rd_hit_q;
  logic [WORD_W-1:0] rd_fill_q;
  logic [WORD_W-1:0] ram_rdata;

  setwi_ram #(
    .DEPTH (WORDS),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (req_i.wr_en),
    .wr_addr_i (req_i.addr),
    .wr_data_i (req_i.wdata),
    .rd_en_i   (req_i.rd_en),
    .rd_addr_i (req_i.addr),
    .rd_data_o (ram_rdata)
  );

  // fill clears every valid bit, a single write marks its word
  always_comb begin
    valid_d = valid_q;
    fill_d  = fill_q;
    if (req_i.fill_en) begin
      valid_d = '0;
      fill_d  = req_i.fill_data;
    end
    if (req_i.wr_en) begin
      valid_d[req_i.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fill_q  <= ERASED_WORD;
    end else begin
      valid_q <= valid_d;
      fill_q  <= fill_d;
    end
  end

  // capture hit and fill value alongside the ram read
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_hit_q  <= valid_q[req_i.addr];
      rd_fill_q <= fill_q;
    end
  end

  assign rd_data_o = rd_hit_q ? ram_rdata : rd_fill_q;

endmodule

>>> sv/setwi_ctrl.sv
// ---------------------------------------------------------------------------
// setwi_ctrl
// Serial protocol engine: tracks select and clock edges, decodes start bit,
// opcode, address and data, and drives the word store.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "serial_eeprom_three_wire_interface_core_macros.svh"

module setwi_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic [7:0]                   control_byte_i,
  input  logic                         res_busy_i,
  output logic                         res_valid_o,
  output logic                         res_bit_o,
  output setwi_pkg::store_req_t        store_req_o,
  input  logic [setwi_pkg::WORD_W-1:0] store_rdata_i
);
  import setwi_pkg::*;

  state_e            state_q, state_d;
  logic              sel_prev_q, sel_prev_d;
  logic              clk_prev_q, clk_prev_d;
  logic              idle_q, idle_d;
  phase_e            phase_q, phase_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [WORD_W-1:0] shift_q, shift_d;
  op_e               op_q, op_d;
  logic [7:0]        addr_q, addr_d;
  logic              wen_q, wen_d;
  logic              out_bit_q, out_bit_d;

  logic accept;
  logic cs, sk, din;
  logic load;

  assign cs  = control_byte_i[7];
  assign sk  = control_byte_i[6];
  assign din = control_byte_i[1];

  // sequencer and protocol next state
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE) || res_busy_i;
    accept      = in_valid_i && !in_stall_o;
    state_d     = state_q;
    sel_prev_d  = sel_prev_q;
    clk_prev_d  = clk_prev_q;
    idle_d      = idle_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    shift_d     = shift_q;
    op_d        = op_q;
    addr_d      = addr_q;
    wen_d       = wen_q;
    out_bit_d   = out_bit_q;
    load        = 1'b0;
    store_req_o = '0;
    store_req_o.addr  = addr_q[ADDR_W-1:0];
    store_req_o.wdata = shift_q;

    case (state_q)
      ST_IDLE: begin
        if (accept && !command_i) begin
          sel_prev_d = cs;
          clk_prev_d = sk;

          // rising select: commit a pending write or arm for a start bit
          if (!sel_prev_q && cs) begin
            if (phase_q == PH_WAIT) begin
              store_req_o.wr_en = wen_q;
              phase_d   = PH_NONE;
              out_bit_d = 1'b1;
            end else begin
              idle_d  = 1'b1;
              phase_d = PH_NONE;
            end
          end

          // rising clock: shift in one bit
          if (!clk_prev_q && sk) begin
            if (idle_d) begin
              if (din) begin
                idle_d  = 1'b0;
                cnt_d   = '0;
                phase_d = PH_OP;
              end
            end else begin
              case (phase_d)
                PH_OP: begin
                  shift_d = {shift_q[WORD_W-2:0], din};
                  cnt_d   = cnt_q + 1'b1;
                  if (cnt_d == CNT_OPCODE) begin
                    phase_d = PH_ADDR;
                    cnt_d   = '0;
                    op_d    = op_e'(shift_d[1:0]);
                  end
                end
                PH_ADDR: begin
                  shift_d = {shift_q[WORD_W-2:0], din};
                  cnt_d   = cnt_q + 1'b1;
                  if (cnt_d == CNT_ADDR) begin
                    phase_d = PH_DATA;
                    cnt_d   = '0;
                    addr_d  = shift_d[7:0];
                    if (op_q == OP_EXT) begin
                      if (ext_e'(addr_d[7:6]) == EXT_EWDS) begin
                        wen_d   = 1'b0;
                        phase_d = PH_NONE;
                      end else if (ext_e'(addr_d[7:6]) == EXT_EWEN) begin
                        wen_d   = 1'b1;
                        phase_d = PH_NONE;
                      end
                    end
                  end
                end
                PH_DATA: begin
                  shift_d = {shift_q[WORD_W-2:0], din};
                  cnt_d   = cnt_q + 1'b1;
                  case (op_q)
                    OP_EXT: begin
                      if (cnt_d == CNT_WORD) begin
                        case (ext_e'(addr_q[7:6]))
                          EXT_EWDS: begin
                            wen_d   = 1'b0;
                            phase_d = PH_NONE;
                          end
                          EXT_WRAL: begin
                            store_req_o.fill_en   = wen_q;
                            store_req_o.fill_data = shift_d;
                            phase_d = PH_WAIT;
                          end
                          EXT_ERAL: begin
                            store_req_o.fill_en   = wen_q;
                            store_req_o.fill_data = ERASED_WORD;
                            shift_d = ERASED_WORD;
                            phase_d = PH_WAIT;
                          end
                          default: begin
                            wen_d   = 1'b1;
                            phase_d = PH_NONE;
                          end
                        endcase
                        cnt_d = '0;
                      end
                    end
                    OP_WRITE: begin
                      if (cnt_d == CNT_WORD) begin
                        cnt_d     = '0;
                        phase_d   = PH_WAIT;
                        out_bit_d = 1'b0;
                      end
                    end
                    OP_READ: begin
                      if (cnt_d == CNT_READ) begin
                        phase_d = PH_RDOUT;
                        cnt_d   = '0;
                        load    = 1'b1;
                      end
                    end
                    default: begin
                      if (cnt_d == CNT_WORD) begin
                        cnt_d     = '0;
                        phase_d   = PH_WAIT;
                        out_bit_d = 1'b0;
                        shift_d   = ERASED_WORD;
                      end
                    end
                  endcase
                end
                default: ;
              endcase
            end
          end

          // falling clock during read out: next data bit
          if (clk_prev_q && !sk && phase_d == PH_RDOUT) begin
            out_bit_d = shift_d[WORD_W-1];
            shift_d   = {shift_d[WORD_W-2:0], 1'b0};
            cnt_d     = cnt_d + 1'b1;
            if (cnt_d == CNT_WORD) begin
              cnt_d   = '0;
              phase_d = PH_NONE;
            end
          end

          if (load) begin
            store_req_o.rd_en = 1'b1;
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        shift_d = store_rdata_i;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    res_valid_o = accept;
    res_bit_o   = out_bit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      sel_prev_q <= 1'b0;
      clk_prev_q <= 1'b0;
      idle_q     <= 1'b0;
      phase_q    <= PH_NONE;
      cnt_q      <= '0;
      shift_q    <= '0;
      op_q       <= OP_EXT;
      addr_q     <= '0;
      wen_q      <= 1'b0;
      out_bit_q  <= 1'b1;
    end else begin
      state_q    <= state_d;
      sel_prev_q <= sel_prev_d;
      clk_prev_q <= clk_prev_d;
      idle_q     <= idle_d;
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      shift_q    <= shift_d;
      op_q       <= op_d;
      addr_q     <= addr_d;
      wen_q      <= wen_d;
      out_bit_q  <= out_bit_d;
    end
  end

  // checks
  `SETWI_ASSERT_NEXT(a_load_one_cycle, state_q == ST_LOAD, state_q == ST_IDLE)
  `SETWI_ASSERT_NOW(a_no_accept_in_load, state_q == ST_LOAD, in_stall_o)
  `SETWI_ASSERT_NOW(a_wr_fill_excl, store_req_o.wr_en, !store_req_o.fill_en)
  `SETWI_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= CNT_WORD)
  `SETWI_ASSERT_NEXT(a_load_enters_rdout, store_req_o.rd_en, phase_q == PH_RDOUT)

endmodule
